// File: hdl/rac_pkg.sv
// Shared types and constants for the rudder angle quadratic calibration block.
// Used by rac_poly, rac_div_stage and the top level; depends on nothing.
package rac_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int ANGLE_BITS    = 18;
  localparam int Y_BITS        = 17;
  localparam int AVG_SHIFT     = 2;   // four samples per group
  localparam int REM_BITS      = 56;
  localparam int Q_BITS        = 18;
  localparam int DIV_STAGES    = 9;   // two quotient bits per stage
  localparam int LATENCY       = 19;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_X_LEFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_CENTER = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_LEFT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_CENTER = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_RIGHT  = 3'd5;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]   x_left;
    logic [SAMPLE_BITS-1:0]   x_center;
    logic [SAMPLE_BITS-1:0]   x_right;
    logic signed [Y_BITS-1:0] y_left;
    logic signed [Y_BITS-1:0] y_center;
    logic signed [Y_BITS-1:0] y_right;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] avg;
    logic                   degen;
    logic                   lo;
    logic                   hi;
  } side_t;

  typedef struct packed {
    logic                valid;
    logic [REM_BITS-1:0] rem;
    logic [REM_BITS-1:0] ds;
    logic [Q_BITS-1:0]   q;
    side_t               side;
  } div_t;

endpackage

// File: hdl/rac_poly.sv
// Averaging and Lagrange numerator/denominator pipeline, ending in the clamp
// compares and the offset dividend for the divider. Depends on rac_pkg.
module rac_poly (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]     s_a,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]     s_b,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]     s_c,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]     s_d,
  input  rac_pkg::cfg_t                       cfg,
  output rac_pkg::div_t                       div_out
);

  // stage valids, v[k] travels with the stage k+1 data
  logic [6:0] v;

  // P1: average
  logic [13:0] sum4;
  logic [11:0] x1;
  // P2: differences and first products
  logic signed [12:0] ex_l, ex_c, ex_r, c01, c02, c12;
  logic signed [25:0] bc2, ac2, ab2, e2;
  logic signed [12:0] d01_2, d02_2, d12_2;
  logic [11:0] avg2, avg3, avg4, avg5, avg6, avg7;
  logic degen2, degen3, degen4, degen5, degen6, degen7;
  // P3
  logic signed [38:0] t0_3, t1_3, t2_3, den3;
  // P4
  logic signed [38:0] t0n, t1n, t2n, denn;
  logic signed [37:0] t0_4, t1_4, t2_4;
  logic [35:0] den4, den5, den6, den7;
  // P5
  logic [36:0] dd;
  logic signed [17:0] yr1;
  logic signed [36:0] pl0, pl1, pl2, ll5;
  logic signed [35:0] ph0, ph1, ph2, lh5;
  logic signed [37:0] hl5;
  logic signed [36:0] hh5;
  // P6
  logic signed [57:0] m0, m1, m2, l6, h6;
  // P7
  logic signed [57:0] n7, l7, h7;
  logic signed [57:0] numc;
  // P8
  logic lo8;
  logic [57:0] diff8;

  assign sum4 = {2'b0, s_a} + {2'b0, s_b} + {2'b0, s_c} + {2'b0, s_d};

  assign ex_l = $signed({1'b0, x1}) - $signed({1'b0, cfg.x_left});
  assign ex_c = $signed({1'b0, x1}) - $signed({1'b0, cfg.x_center});
  assign ex_r = $signed({1'b0, x1}) - $signed({1'b0, cfg.x_right});
  assign c01  = $signed({1'b0, cfg.x_left})   - $signed({1'b0, cfg.x_center});
  assign c02  = $signed({1'b0, cfg.x_left})   - $signed({1'b0, cfg.x_right});
  assign c12  = $signed({1'b0, cfg.x_center}) - $signed({1'b0, cfg.x_right});

  assign t0n  = den3[38] ? -t0_3 : t0_3;
  assign t1n  = den3[38] ? -t1_3 : t1_3;
  assign t2n  = den3[38] ? -t2_3 : t2_3;
  assign denn = den3[38] ? -den3 : den3;

  assign dd  = {den4, 1'b0};
  assign yr1 = $signed({cfg.y_right[16], cfg.y_right}) + 18'sd1;

  assign numc = m0 - m1 + m2;
  assign lo8  = n7 < l7;
  assign diff8 = n7 - l7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v             <= '0;
      div_out.valid <= 1'b0;
    end else begin
      v             <= {v[5:0], in_valid};
      div_out.valid <= v[6];
    end
    // P1
    x1 <= sum4[13:rac_pkg::AVG_SHIFT];
    // P2
    avg2   <= x1;
    degen2 <= (c01 == 13'sd0) || (c02 == 13'sd0) || (c12 == 13'sd0);
    bc2    <= ex_c * ex_r;
    ac2    <= ex_l * ex_r;
    ab2    <= ex_l * ex_c;
    e2     <= c01 * c02;
    d01_2  <= c01;
    d02_2  <= c02;
    d12_2  <= c12;
    // P3
    avg3   <= avg2;
    degen3 <= degen2;
    t0_3   <= bc2 * d12_2;
    t1_3   <= ac2 * d02_2;
    t2_3   <= ab2 * d01_2;
    den3   <= e2 * d12_2;
    // P4: make denominator positive
    avg4   <= avg3;
    degen4 <= degen3;
    t0_4   <= t0n[37:0];
    t1_4   <= t1n[37:0];
    t2_4   <= t2n[37:0];
    den4   <= denn[35:0];
    // P5: split products
    avg5   <= avg4;
    degen5 <= degen4;
    den5   <= den4;
    pl0 <= cfg.y_left   * $signed({1'b0, t0_4[18:0]});
    ph0 <= cfg.y_left   * $signed(t0_4[37:19]);
    pl1 <= cfg.y_center * $signed({1'b0, t1_4[18:0]});
    ph1 <= cfg.y_center * $signed(t1_4[37:19]);
    pl2 <= cfg.y_right  * $signed({1'b0, t2_4[18:0]});
    ph2 <= cfg.y_right  * $signed(t2_4[37:19]);
    ll5 <= cfg.y_left * $signed({1'b0, dd[18:0]});
    lh5 <= cfg.y_left * $signed({1'b0, dd[36:19]});
    hl5 <= yr1 * $signed({1'b0, dd[18:0]});
    hh5 <= yr1 * $signed({1'b0, dd[36:19]});
    // P6: assemble partial products
    avg6   <= avg5;
    degen6 <= degen5;
    den6   <= den5;
    m0 <= $signed({{3{ph0[35]}}, ph0, 19'b0}) + $signed({{21{pl0[36]}}, pl0});
    m1 <= $signed({{3{ph1[35]}}, ph1, 19'b0}) + $signed({{21{pl1[36]}}, pl1});
    m2 <= $signed({{3{ph2[35]}}, ph2, 19'b0}) + $signed({{21{pl2[36]}}, pl2});
    l6 <= $signed({{3{lh5[35]}}, lh5, 19'b0}) + $signed({{21{ll5[36]}}, ll5});
    h6 <= $signed({{2{hh5[36]}}, hh5, 19'b0}) + $signed({{20{hl5[37]}}, hl5});
    // P7: 2*num + den for round half up
    avg7   <= avg6;
    degen7 <= degen6;
    den7   <= den6;
    n7     <= $signed({numc[56:0], 1'b0}) + $signed({22'b0, den6});
    l7     <= l6;
    h7     <= h6;
    // P8 goes straight into the divider input register
    div_out.rem        <= diff8[rac_pkg::REM_BITS-1:0];
    div_out.ds         <= {2'b0, den7, 18'b0};
    div_out.q          <= '0;
    div_out.side.avg   <= avg7;
    div_out.side.degen <= degen7;
    div_out.side.lo    <= lo8;
    div_out.side.hi    <= !lo8 && !(n7 < h7);
  end

endmodule

// File: hdl/rac_div_stage.sv
// One registered stage of the restoring divider: two quotient bits per stage.
// Depends on rac_pkg.
module rac_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  rac_pkg::div_t d_in,
  output rac_pkg::div_t d_out
);

  rac_pkg::div_t nxt;

  always_comb begin
    nxt = d_in;
    for (int i = 0; i < 2; i++) begin
      if (nxt.rem >= nxt.ds) begin
        nxt.rem = nxt.rem - nxt.ds;
        nxt.q   = {nxt.q[rac_pkg::Q_BITS-2:0], 1'b1};
      end else begin
        nxt.q   = {nxt.q[rac_pkg::Q_BITS-2:0], 1'b0};
      end
      nxt.rem = {nxt.rem[rac_pkg::REM_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out.valid <= d_in.valid;
    end
    d_out.rem  <= nxt.rem;
    d_out.ds   <= nxt.ds;
    d_out.q    <= nxt.q;
    d_out.side <= nxt.side;
  end

endmodule

// File: hdl/rudder_angle_quadratic_calibration_top.sv
// Throughput: one sample group per cycle; busy is always low, no stalls.
// Depth is set by the multiply chain (8 stages) and the 18-bit divider (9).
// Reset (rst, synchronous): pipeline valids clear, config returns to defaults.
// Results cannot be held off: done marks each result for one cycle.
module rudder_angle_quadratic_calibration_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]        sample_a,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]        sample_b,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]        sample_c,
  input  logic [rac_pkg::SAMPLE_BITS-1:0]        sample_d,
  input  logic                                   wr_en,
  input  logic [rac_pkg::CFG_IDX_BITS-1:0]       wr_index,
  input  logic [rac_pkg::Y_BITS-1:0]             wr_data,
  output logic                                   done,
  output logic [rac_pkg::SAMPLE_BITS-1:0]        native_avg,
  output logic signed [rac_pkg::ANGLE_BITS-1:0]  angle,
  output logic                                   degenerate,
  output logic                                   clamped_low,
  output logic                                   clamped_high
);

  rac_pkg::cfg_t cfg;

  // Input capture
  logic                            in_valid;
  logic [rac_pkg::SAMPLE_BITS-1:0] s_a, s_b, s_c, s_d;
  logic                            accept;

  rac_pkg::div_t div_chain [rac_pkg::DIV_STAGES+1];

  // Final select
  rac_pkg::div_t                         fin;
  logic signed [rac_pkg::ANGLE_BITS-1:0] q_full;
  logic signed [rac_pkg::ANGLE_BITS-1:0] yl_ext, yr_ext;
  logic                                  lo_f, hi_f;
  logic signed [rac_pkg::ANGLE_BITS-1:0] angle_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_left   <= 12'd100;
      cfg.x_center <= 12'd1950;
      cfg.x_right  <= 12'd4000;
      cfg.y_left   <= -17'sd23040;
      cfg.y_center <= 17'sd0;
      cfg.y_right  <= 17'sd23040;
    end else if (wr_en) begin
      unique case (wr_index)
        rac_pkg::REG_X_LEFT:   cfg.x_left   <= wr_data[rac_pkg::SAMPLE_BITS-1:0];
        rac_pkg::REG_X_CENTER: cfg.x_center <= wr_data[rac_pkg::SAMPLE_BITS-1:0];
        rac_pkg::REG_X_RIGHT:  cfg.x_right  <= wr_data[rac_pkg::SAMPLE_BITS-1:0];
        rac_pkg::REG_Y_LEFT:   cfg.y_left   <= $signed(wr_data);
        rac_pkg::REG_Y_CENTER: cfg.y_center <= $signed(wr_data);
        rac_pkg::REG_Y_RIGHT:  cfg.y_right  <= $signed(wr_data);
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    s_a <= sample_a;
    s_b <= sample_b;
    s_c <= sample_c;
    s_d <= sample_d;
  end

  // Polynomial and compare stages; output is the divider input register
  rac_poly u_poly (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .s_a      (s_a),
    .s_b      (s_b),
    .s_c      (s_c),
    .s_d      (s_d),
    .cfg      (cfg),
    .div_out  (div_chain[0])
  );

  // Restoring divider: quotient of (2N + D - 2*y_left*D) by 2D, only used in range
  for (genvar g = 0; g < rac_pkg::DIV_STAGES; g++) begin : g_div
    rac_div_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .d_in  (div_chain[g]),
      .d_out (div_chain[g+1])
    );
  end

  assign fin    = div_chain[rac_pkg::DIV_STAGES];
  assign yl_ext = $signed({cfg.y_left[16], cfg.y_left});
  assign yr_ext = $signed({cfg.y_right[16], cfg.y_right});
  assign q_full = yl_ext + $signed(fin.q);

  // Degenerate points: polynomial is zero, so clamps test zero directly
  always_comb begin
    if (fin.side.degen) begin
      lo_f = yl_ext > 18'sd0;
      hi_f = !lo_f && (yr_ext < 18'sd0);
    end else begin
      lo_f = fin.side.lo;
      hi_f = fin.side.hi;
    end
    if (lo_f) begin
      angle_next = yl_ext;
    end else if (hi_f) begin
      angle_next = yr_ext;
    end else if (fin.side.degen) begin
      angle_next = '0;
    end else begin
      angle_next = q_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    native_avg   <= fin.side.avg;
    angle        <= angle_next;
    degenerate   <= fin.side.degen;
    clamped_low  <= lo_f;
    clamped_high <= hi_f;
  end

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(rac_pkg::LATENCY) done)
    else $error("result missing after fixed latency");

  a_one_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> !(clamped_low && clamped_high))
    else $error("both clamps set");

  a_low_value: assert property (@(posedge clk) disable iff (rst)
    (done && clamped_low) |-> (angle == yl_ext))
    else $error("low clamp value wrong");

  a_high_value: assert property (@(posedge clk) disable iff (rst)
    (done && clamped_high) |-> (angle == yr_ext))
    else $error("high clamp value wrong");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate && !clamped_low && !clamped_high) |-> (angle == '0))
    else $error("degenerate result not zero");

endmodule

// File: test/tb_rudder_angle_quadratic_calibration_top.sv
// Self-checking testbench for rudder_angle_quadratic_calibration_top.
// Depends on rac_pkg and the top level only; holds its own angle predictor.
`timescale 1ns / 100ps

module tb_rudder_angle_quadratic_calibration_top;

  localparam int  CLK_HALF   = 6;
  localparam int  RAND_ITEMS = 1750;
  localparam int  RAND_SETS  = 8;
  localparam int  MAX_SHOWN  = 10;
  localparam longint ANG_MAX = 131071;
  localparam longint ANG_MIN = -131072;

  // Calibration as the predictor sees it: plain signed integers.
  typedef struct {
    longint xl, xc, xr;
    longint yl, yc, yr;
  } cal_t;

  // One expected angle result.
  typedef struct packed {
    logic [rac_pkg::SAMPLE_BITS-1:0] avg;
    logic [rac_pkg::ANGLE_BITS-1:0]  ang;
    logic                            degen;
    logic                            lo;
    logic                            hi;
  } angle_res_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  logic [rac_pkg::SAMPLE_BITS-1:0]  sample_a = '0, sample_b = '0;
  logic [rac_pkg::SAMPLE_BITS-1:0]  sample_c = '0, sample_d = '0;
  logic                             wr_en = 1'b0;
  logic [rac_pkg::CFG_IDX_BITS-1:0] wr_index = rac_pkg::REG_X_LEFT;
  logic [rac_pkg::Y_BITS-1:0]       wr_data = '0;
  logic                             done;
  logic [rac_pkg::SAMPLE_BITS-1:0]  native_avg;
  logic signed [rac_pkg::ANGLE_BITS-1:0] angle;
  logic                             degenerate, clamped_low, clamped_high;

  cal_t       cal;               // shadow of the block's registers
  angle_res_t pending_angles[$]; // predicted results, oldest first
  int         mismatches = 0;
  bit         steady = 0;        // no idling while set

  always #(CLK_HALF) clk = ~clk;

  rudder_angle_quadratic_calibration_top DUT (.*);

  // ---------------------------------------------------------------------------
  // Predictor: truncated mean, Lagrange quadratic over a common denominator,
  // round half up, lower clamp first, then upper clamp, then saturation.
  // ---------------------------------------------------------------------------
  function automatic angle_res_t calc_angle(input logic [rac_pkg::SAMPLE_BITS-1:0] a, b, c, d);
    angle_res_t res;
    longint x, d01, d02, d12, den, num, q, r, ang;
    bit degen, lo, hi;
    x = (longint'(a) + longint'(b) + longint'(c) + longint'(d)) / 4;
    degen = (cal.xl == cal.xc) || (cal.xl == cal.xr) || (cal.xc == cal.xr);
    q = 0;
    lo = 0;
    hi = 0;
    if (!degen) begin
      d01 = cal.xl - cal.xc;
      d02 = cal.xl - cal.xr;
      d12 = cal.xc - cal.xr;
      den = d01 * d02 * d12;
      num = cal.yl * ((x - cal.xc) * (x - cal.xr) * d12)
          - cal.yc * ((x - cal.xl) * (x - cal.xr) * d02)
          + cal.yr * ((x - cal.xl) * (x - cal.xc) * d01);
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      q = num / den;
      r = num % den;
      if (r < 0) begin   // floor, then round half toward plus infinity
        q = q - 1;
        r = r + den;
      end
      if (2 * r >= den) q = q + 1;
    end
    ang = q;
    if (ang < cal.yl) begin
      ang = cal.yl;
      lo = 1;
    end else if (ang > cal.yr) begin
      ang = cal.yr;
      hi = 1;
    end
    if (ang > ANG_MAX) ang = ANG_MAX;
    if (ang < ANG_MIN) ang = ANG_MIN;
    res.avg   = x[rac_pkg::SAMPLE_BITS-1:0];
    res.ang   = ang[rac_pkg::ANGLE_BITS-1:0];
    res.degen = degen;
    res.lo    = lo;
    res.hi    = hi;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. Outputs change on the rising edge, so they are sampled
  // mid-cycle at the falling edge; done is high for one cycle per result.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    angle_res_t want, got;
    if (!rst && done) begin
      got = '{native_avg, angle, degenerate, clamped_low, clamped_high};
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected result avg=%0d angle=%0d", $realtime, native_avg, angle);
      end else begin
        want = pending_angles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: mismatch avg %0d/%0d angle %0d/%0d degen %b/%b lo %b/%b hi %b/%b",
                     $realtime, want.avg, native_avg, $signed(want.ang), angle,
                     want.degen, degenerate, want.lo, clamped_low, want.hi, clamped_high);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Present one sample group; returns right after the edge that took it.
  // start stays high so a back-to-back transfer needs no extra edge.
  task automatic send_group(input logic [rac_pkg::SAMPLE_BITS-1:0] a, b, c, d);
    start    <= 1'b1;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    sample_d <= d;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_angles.push_back(calc_angle(a, b, c, d));
  endtask

  // Random gap after a transfer: mostly none, some short, a few long.
  task automatic sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return;
    start <= 1'b0;
    if (pick < 93) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(8, 40)) @(posedge clk);
  endtask

  // Let every expected result come out, then the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (rac_pkg::LATENCY + 4) @(posedge clk);
  endtask

  // Write all six registers back to back, once the pipeline is empty.
  task automatic load_cal(input int xl, xc, xr, yl, yc, yr);
    logic [rac_pkg::CFG_IDX_BITS-1:0] idx[6];
    int vals[6];
    drain();
    idx  = '{rac_pkg::REG_X_LEFT, rac_pkg::REG_X_CENTER, rac_pkg::REG_X_RIGHT,
             rac_pkg::REG_Y_LEFT, rac_pkg::REG_Y_CENTER, rac_pkg::REG_Y_RIGHT};
    vals = '{xl, xc, xr, yl, yc, yr};
    for (int i = 0; i < 6; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= vals[i][rac_pkg::Y_BITS-1:0];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    @(posedge clk);
    cal.xl = xl & 12'hFFF;
    cal.xc = xc & 12'hFFF;
    cal.xr = xr & 12'hFFF;
    cal.yl = longint'($signed(vals[3][rac_pkg::Y_BITS-1:0]));
    cal.yc = longint'($signed(vals[4][rac_pkg::Y_BITS-1:0]));
    cal.yr = longint'($signed(vals[5][rac_pkg::Y_BITS-1:0]));
  endtask

  function automatic logic [rac_pkg::SAMPLE_BITS-1:0] near(input longint ctr, input int spread);
    longint v;
    v = ctr + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[rac_pkg::SAMPLE_BITS-1:0];
  endfunction

  // One random group: full range, tight cluster, near a calibration point,
  // or a rail.
  task automatic send_random_group();
    longint ctr;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4)
      send_group($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
    else begin
      case ($urandom_range(0, 4))
        0: ctr = cal.xl;
        1: ctr = cal.xc;
        2: ctr = cal.xr;
        3: ctr = $urandom_range(0, 1) ? 0 : 4095;
        default: ctr = $urandom_range(0, 4095);
      endcase
      send_group(near(ctr, 3), near(ctr, 3), near(ctr, 3), near(ctr, 3));
    end
    sender_gap();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset calibration; rails, truncation of the mean and the three points.
  task automatic test_reset_defaults();
    cal = '{100, 1950, 4000, -23040, 0, 23040};
    send_group(0, 0, 0, 0);
    send_group(4095, 4095, 4095, 4095);
    send_group(4095, 4095, 4095, 4094);   // mean truncates to 4094
    send_group(1, 0, 0, 0);                // mean truncates to 0
    send_group(100, 100, 100, 100);
    send_group(1950, 1950, 1950, 1951);
    send_group(4000, 4000, 4000, 4000);
    send_group(12'hAAA, 12'h555, 12'hAAA, 12'h555);
    drain();
  endtask

  // Full-scale calibration; quadratic that overshoots hits both clamps.
  task automatic test_extreme_cal();
    load_cal(0, 2048, 4095, -46080, 46080, 46080);
    send_group(0, 0, 0, 0);
    send_group(1024, 1024, 1024, 1024);
    send_group(3000, 3000, 3000, 3000);
    send_group(4095, 4095, 4095, 4095);
    load_cal(4095, 1, 0, 46080, -46080, -46080);  // points in falling order
    send_group(0, 0, 0, 0);
    send_group(2, 2, 2, 2);
    send_group(4095, 4095, 4095, 4095);
    drain();
  endtask

  // Coinciding raw points force zero; clamps still apply.
  task automatic test_degenerate();
    load_cal(500, 500, 3000, -100, 0, 100);
    send_group(0, 0, 0, 0);
    load_cal(500, 2000, 500, 300, 0, 900);        // zero below y_left
    send_group(4095, 4095, 4095, 4095);
    load_cal(10, 2000, 2000, -900, 0, -300);      // zero above y_right
    send_group(2000, 2000, 2000, 2000);
    load_cal(7, 7, 7, 0, 0, 0);
    send_group(7, 7, 7, 7);
    drain();
  endtask

  // y_left above y_right: anything not below y_left ends at y_right.
  task automatic test_crossed_clamps();
    load_cal(100, 2000, 4000, 5000, 0, -5000);
    send_group(100, 100, 100, 100);
    send_group(2000, 2000, 2000, 2000);
    send_group(4000, 4000, 4000, 4000);
    drain();
  endtask

  // Random groups over several random calibrations, with idling phases.
  task automatic test_random();
    int xl, xc, xr;
    for (int s = 0; s < RAND_SETS; s++) begin
      xl = $urandom_range(0, 4095);
      xc = $urandom_range(0, 4095);
      xr = $urandom_range(0, 4095);
      if ($urandom_range(0, 5) == 0) xc = xl;   // now and then degenerate
      load_cal(xl, xc, xr,
               $urandom_range(0, 92160) - 46080,
               $urandom_range(0, 92160) - 46080,
               $urandom_range(0, 92160) - 46080);
      for (int i = 0; i < RAND_ITEMS / RAND_SETS; i++) begin
        if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
        send_random_group();
      end
      steady = 0;
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_cal();
    test_degenerate();
    test_crossed_clamps();
    test_random();
    if (mismatches == 0)
      $display("[rudder_angle_quadratic_calibration_top] OK");
    else
      $display("[rudder_angle_quadratic_calibration_top] ERROR");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("[rudder_angle_quadratic_calibration_top] ERROR");
    $finish;
  end

endmodule
